// ----- hw/rtl/hsl_ckm_pkg.sv -----
// Shared constants and types for the HSL color key mask block.
`timescale 1ns / 1ps
package hsl_ckm_pkg;

    // Fraction bits of hue, lightness and saturation.
    localparam int FRAC_BITS = 16;
    // Tolerances are always Q0.16 with one extra bit so they can hold 1.0.
    localparam int TOL_FRAC = 16;
    localparam int TOL_W = TOL_FRAC + 1;

    // Divider operands cover numerators and denominators up to 6 * 255.
    localparam int DIV_W = 11;
    localparam int DIV_STEP = 4;
    localparam int DIV_STAGES = (FRAC_BITS + DIV_STEP - 1) / DIV_STEP;
    // Operand register, step stages, rounding register.
    localparam int DIV_LAT = DIV_STAGES + 2;

    // Quotients reach 1.0 exactly, so one integer bit.
    localparam int HSL_W = FRAC_BITS + 1;
    localparam int CMP_W = HSL_W + 1 + TOL_FRAC + 1;

    // Configuration register indexes.
    localparam logic [2:0] REG_TARGET_RED = 3'd0;
    localparam logic [2:0] REG_TARGET_GREEN = 3'd1;
    localparam logic [2:0] REG_TARGET_BLUE = 3'd2;
    localparam logic [2:0] REG_CHECK_ENABLES = 3'd3;
    localparam logic [2:0] REG_HUE_TOL = 3'd4;
    localparam logic [2:0] REG_LUMA_TOL = 3'd5;
    localparam logic [2:0] REG_SAT_TOL = 3'd6;
    localparam logic [2:0] REG_SHOW_MASK = 3'd7;

    // Division operands for one color.
    typedef struct packed {
        logic [DIV_W-1:0] l_num;
        logic [DIV_W-1:0] l_den;
        logic [DIV_W-1:0] s_num;
        logic [DIV_W-1:0] s_den;
        logic [DIV_W-1:0] h_num;
        logic [DIV_W-1:0] h_den;
        logic             grey;
    } hsl_ops_t;

    // Pixel data carried alongside the conversion.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       pix_grey;
        logic       tgt_grey;
    } side_t;

endpackage

// ----- hw/rtl/hsl_ckm_prep.sv -----
// Max/min analysis of one RGB color into the operands of its three divisions.
`timescale 1ns / 1ps
module hsl_ckm_prep (
    input  logic [7:0]              red,
    input  logic [7:0]              green,
    input  logic [7:0]              blue,
    output hsl_ckm_pkg::hsl_ops_t   ops
);
    import hsl_ckm_pkg::*;

    logic [7:0]       hi;
    logic [7:0]       lo;
    logic [DIV_W-1:0] d;
    logic [DIV_W-1:0] sum;
    logic [DIV_W-1:0] r;
    logic [DIV_W-1:0] g;
    logic [DIV_W-1:0] b;

    // Extremes of the three channels.
    always_comb
    begin
        hi = red;
        lo = red;
        if (green > hi) hi = green;
        if (blue > hi) hi = blue;
        if (green < lo) lo = green;
        if (blue < lo) lo = blue;
        r = DIV_W'(red);
        g = DIV_W'(green);
        b = DIV_W'(blue);
        d = DIV_W'(hi) - DIV_W'(lo);
        sum = DIV_W'(hi) + DIV_W'(lo);
    end

    // Operands: lightness over 510, saturation over the nearer end, hue over 6d.
    always_comb
    begin
        ops.l_num = sum;
        ops.l_den = DIV_W'(510);
        ops.s_num = d;
        ops.s_den = (sum < DIV_W'(255)) ? sum : DIV_W'(510) - sum;
        ops.h_den = (d << 2) + (d << 1);
        if (hi == red)
        begin
            ops.h_num = (green >= blue) ? g - b : ops.h_den - (b - g);
        end
        else if (hi == green)
        begin
            ops.h_num = (d << 1) + b - r;
        end
        else
        begin
            ops.h_num = (d << 2) + r - g;
        end
        ops.grey = (d == '0);
    end

endmodule

// ----- hw/rtl/hsl_ckm_div.sv -----
// Pipelined restoring divider giving round(num * 2^F / den) for num <= den.
`timescale 1ns / 1ps
module hsl_ckm_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [hsl_ckm_pkg::DIV_W-1:0]  num,
    input  logic [hsl_ckm_pkg::DIV_W-1:0]  den,
    output logic [hsl_ckm_pkg::HSL_W-1:0]  quo
);
    import hsl_ckm_pkg::*;

    logic [DIV_W-1:0] rem_reg [0:DIV_STAGES];
    logic [DIV_W-1:0] den_reg [0:DIV_STAGES];
    logic [HSL_W-1:0] q_reg [0:DIV_STAGES];
    logic [DIV_W-1:0] rem_next [1:DIV_STAGES];
    logic [HSL_W-1:0] q_next [1:DIV_STAGES];
    logic [HSL_W-1:0] quo_reg;
    logic             first_bit;
    logic [DIV_W:0]   round_sum;
    logic [DIV_W-1:0] rem_work;
    logic [HSL_W-1:0] q_work;
    logic [DIV_W:0]   trial;

    // Integer bit of the quotient, then the remainder below den.
    assign first_bit = (num >= den);

    // Each stage resolves up to DIV_STEP fraction bits.
    always_comb
    begin
        rem_work = '0;
        q_work = '0;
        trial = '0;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_work = rem_reg[s];
            q_work = q_reg[s];
            for (int k = 0; k < DIV_STEP; k++)
            begin
                if (s * DIV_STEP + k < FRAC_BITS)
                begin
                    trial = {rem_work, 1'b0};
                    if (trial >= {1'b0, den_reg[s]})
                    begin
                        rem_work = DIV_W'(trial - {1'b0, den_reg[s]});
                        q_work = {q_work[HSL_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_work = DIV_W'(trial);
                        q_work = {q_work[HSL_W-2:0], 1'b0};
                    end
                end
            end
            rem_next[s+1] = rem_work;
            q_next[s+1] = q_work;
        end
    end

    // Round half up: add one when the remainder reaches half the divisor.
    assign round_sum = {1'b0, rem_reg[DIV_STAGES]}
        + {2'b0, den_reg[DIV_STAGES][DIV_W-1:1]};

    // Operand register, step stages and rounding register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= first_bit ? num - den : num;
            den_reg[0] <= den;
            q_reg[0] <= HSL_W'(first_bit);
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_reg[s-1];
                q_reg[s] <= q_next[s];
            end
            quo_reg <= q_reg[DIV_STAGES]
                + HSL_W'(round_sum >= {1'b0, den_reg[DIV_STAGES]});
        end
    end

    assign quo = quo_reg;

endmodule

// ----- hw/rtl/hsl_color_key_mask.sv -----
// Top level of the HSL color key mask: configuration, pipeline control and tests.
`timescale 1ns / 1ps
// The block takes one RGBA8 pixel per clock and returns one pixel per clock,
// in order, while the output does not stall. Six pipelined restoring
// dividers convert the pixel and the key color to HSL, four quotient bits
// per stage. A stall on the output freezes the whole pipeline and is passed
// back to the input in the same cycle. Configuration writes are always taken
// and must only be made while no item is in flight.
module hsl_color_key_mask (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_valid,
    output logic        pix_stall,
    input  logic [7:0]  pix_alpha,
    input  logic [7:0]  pix_red,
    input  logic [7:0]  pix_green,
    input  logic [7:0]  pix_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_alpha,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import hsl_ckm_pkg::*;

    localparam int NUM_STAGES = DIV_LAT + 3;

    logic [7:0]       target_red_reg;
    logic [7:0]       target_green_reg;
    logic [7:0]       target_blue_reg;
    logic [2:0]       check_enables_reg;
    logic [TOL_W-1:0] hue_tol_reg;
    logic [TOL_W-1:0] luma_tol_reg;
    logic [TOL_W-1:0] sat_tol_reg;
    logic             show_mask_reg;

    logic             en;
    logic [NUM_STAGES-1:0] vld_reg;

    hsl_ops_t         pix_ops;
    hsl_ops_t         tgt_ops;
    hsl_ops_t         pix_ops_reg;
    hsl_ops_t         tgt_ops_reg;
    side_t            side_reg [0:DIV_LAT];
    side_t            side_in;

    logic [HSL_W-1:0] pl_q, ps_q, ph_q, tl_q, ts_q, th_q;
    logic [HSL_W-1:0] ph, ps, th, ts;
    logic [HSL_W-1:0] hue_e, hue_alt;
    logic [HSL_W-1:0] hue_dist_reg, luma_dist_reg, sat_dist_reg;
    side_t            dist_side_reg;

    logic [CMP_W-1:0] hue_lhs, luma_lhs, sat_lhs;
    logic [CMP_W-1:0] hue_rhs, luma_rhs, sat_rhs;
    logic             hue_fail, luma_fail, sat_fail;
    logic [7:0]       mask_alpha;
    logic [7:0]       alpha_next, red_next, green_next, blue_next;
    logic [7:0]       alpha_reg, red_reg, green_reg, blue_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_red_reg <= 8'd128;
            target_green_reg <= 8'd255;
            target_blue_reg <= 8'd255;
            check_enables_reg <= 3'd1;
            hue_tol_reg <= TOL_W'(19661);
            luma_tol_reg <= TOL_W'(19661);
            sat_tol_reg <= TOL_W'(19661);
            show_mask_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TARGET_RED:    target_red_reg <= cfg_data[7:0];
                REG_TARGET_GREEN:  target_green_reg <= cfg_data[7:0];
                REG_TARGET_BLUE:   target_blue_reg <= cfg_data[7:0];
                REG_CHECK_ENABLES: check_enables_reg <= cfg_data[2:0];
                REG_HUE_TOL:       hue_tol_reg <= cfg_data[TOL_W-1:0];
                REG_LUMA_TOL:      luma_tol_reg <= cfg_data[TOL_W-1:0];
                REG_SAT_TOL:       sat_tol_reg <= cfg_data[TOL_W-1:0];
                REG_SHOW_MASK:     show_mask_reg <= cfg_data[0];
                default:           show_mask_reg <= show_mask_reg;
            endcase
        end
    end

    // The pipeline moves unless a finished item is held at the output.
    assign en = !(vld_reg[NUM_STAGES-1] && out_stall);
    assign pix_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], pix_valid};
        end
    end

    // Stage 1: division operands for the pixel and the key color.
    hsl_ckm_prep u_prep_pix (
        .red   (pix_red),
        .green (pix_green),
        .blue  (pix_blue),
        .ops   (pix_ops)
    );

    hsl_ckm_prep u_prep_tgt (
        .red   (target_red_reg),
        .green (target_green_reg),
        .blue  (target_blue_reg),
        .ops   (tgt_ops)
    );

    always_comb
    begin
        side_in.alpha = pix_alpha;
        side_in.red = pix_red;
        side_in.green = pix_green;
        side_in.blue = pix_blue;
        side_in.pix_grey = pix_ops.grey;
        side_in.tgt_grey = tgt_ops.grey;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_ops_reg <= pix_ops;
            tgt_ops_reg <= tgt_ops;
            side_reg[0] <= side_in;
            for (int i = 1; i <= DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Divider stages: six quotients in parallel.
    hsl_ckm_div u_div_pl (.clk(clk), .en(en), .num(pix_ops_reg.l_num),
                          .den(pix_ops_reg.l_den), .quo(pl_q));
    hsl_ckm_div u_div_ps (.clk(clk), .en(en), .num(pix_ops_reg.s_num),
                          .den(pix_ops_reg.s_den), .quo(ps_q));
    hsl_ckm_div u_div_ph (.clk(clk), .en(en), .num(pix_ops_reg.h_num),
                          .den(pix_ops_reg.h_den), .quo(ph_q));
    hsl_ckm_div u_div_tl (.clk(clk), .en(en), .num(tgt_ops_reg.l_num),
                          .den(tgt_ops_reg.l_den), .quo(tl_q));
    hsl_ckm_div u_div_ts (.clk(clk), .en(en), .num(tgt_ops_reg.s_num),
                          .den(tgt_ops_reg.s_den), .quo(ts_q));
    hsl_ckm_div u_div_th (.clk(clk), .en(en), .num(tgt_ops_reg.h_num),
                          .den(tgt_ops_reg.h_den), .quo(th_q));

    // Grey colors have zero hue and saturation; hue wraps at 1.0.
    always_comb
    begin
        ps = side_reg[DIV_LAT].pix_grey ? '0 : ps_q;
        ts = side_reg[DIV_LAT].tgt_grey ? '0 : ts_q;
        ph = side_reg[DIV_LAT].pix_grey ? '0 : {1'b0, ph_q[FRAC_BITS-1:0]};
        th = side_reg[DIV_LAT].tgt_grey ? '0 : {1'b0, th_q[FRAC_BITS-1:0]};
        hue_e = (th > ph) ? th - ph : ph - th;
        hue_alt = (HSL_W'(1) << FRAC_BITS) - hue_e;
    end

    // Distance stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_dist_reg <= (hue_alt < hue_e) ? hue_alt : hue_e;
            luma_dist_reg <= (tl_q > pl_q) ? tl_q - pl_q : pl_q - tl_q;
            sat_dist_reg <= (ts > ps) ? ts - ps : ps - ts;
            dist_side_reg <= side_reg[DIV_LAT];
        end
    end

    // Exact compare of Q0.F distance against Q0.16 tolerance; hue uses tol / 2.
    always_comb
    begin
        hue_lhs = CMP_W'(hue_dist_reg) << (TOL_FRAC + 1);
        luma_lhs = CMP_W'(luma_dist_reg) << TOL_FRAC;
        sat_lhs = CMP_W'(sat_dist_reg) << TOL_FRAC;
        hue_rhs = CMP_W'(hue_tol_reg) << FRAC_BITS;
        luma_rhs = CMP_W'(luma_tol_reg) << FRAC_BITS;
        sat_rhs = CMP_W'(sat_tol_reg) << FRAC_BITS;
        hue_fail = check_enables_reg[0] && (hue_lhs > hue_rhs);
        luma_fail = check_enables_reg[1] && (luma_lhs > luma_rhs);
        sat_fail = check_enables_reg[2] && (sat_lhs > sat_rhs);
        mask_alpha = show_mask_reg ? 8'd255 : 8'd0;
        alpha_next = (hue_fail || luma_fail || sat_fail) ? mask_alpha
                                                         : dist_side_reg.alpha;
        red_next = hue_fail ? 8'd255 : dist_side_reg.red;
        green_next = luma_fail ? 8'd255 : dist_side_reg.green;
        blue_next = sat_fail ? 8'd255 : dist_side_reg.blue;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_reg <= alpha_next;
            red_reg <= red_next;
            green_reg <= green_next;
            blue_reg <= blue_next;
        end
    end

    assign out_valid = vld_reg[NUM_STAGES-1];
    assign out_alpha = alpha_reg;
    assign out_red = red_reg;
    assign out_green = green_reg;
    assign out_blue = blue_reg;

endmodule
